[rtl/core/tdq_pkg.sv]
// tdq_pkg: shared types and constants of the timer deadline queue.
// Used by tdq_cell and timer_deadline_queue; no dependencies.

package tdq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned DlW        = 48;
  localparam int unsigned TagW       = 32;
  localparam int unsigned PerW       = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;

  typedef enum logic [0:0] {
    OpAdd  = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KindAdd    = 2'd0,
    KindExpire = 2'd1,
    KindTick   = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegTaskTag    = 2'd0,
    RegTaskPeriod = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StAdd,
    StScan,
    StRearm
  } state_e;

  typedef struct packed {
    logic [0:0]             op;
    logic [DlW-1:0]         new_deadline;
    logic signed [TagW-1:0] new_tag;
  } cmd_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [DlW-1:0]         fired_deadline;
    logic signed [TagW-1:0] fired_tag;
    logic                   switch_task;
    logic                   dropped;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [DlW-1:0]  dl;
    logic [TagW-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } cell_ctl_t;

endpackage

[rtl/core/tdq_cell.sv]
// tdq_cell: one slot of the sorted timer chain.
// Depends on tdq_pkg. Shifts right on insert, left on pop.

module tdq_cell (
  input  logic               clk_i,
  input  tdq_pkg::cell_ctl_t ctl_i,
  input  logic               valid_i,
  input  tdq_pkg::entry_t    prev_ent_i,
  input  logic               prev_gt_i,
  input  tdq_pkg::entry_t    next_ent_i,
  output tdq_pkg::entry_t    ent_o,
  output logic               gt_o
);
  import tdq_pkg::*;

  entry_t ent_q, ent_d;

  // slot is later than the new timer (or empty); ties stay ahead
  assign gt_o  = !valid_i || (ent_q.dl > ctl_i.ent.dl);
  assign ent_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.ins && gt_o) begin
      ent_d = prev_gt_i ? prev_ent_i : ctl_i.ent;
    end else if (ctl_i.pop) begin
      ent_d = next_ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

[rtl/core/timer_deadline_queue.sv]
// timer_deadline_queue: tick counter with a deadline-sorted chain of timer cells.
// Depends on tdq_pkg and tdq_cell.
//
// Usage: drive cmd_i and raise start while busy is low; the command is
// taken at that edge. An add command (op 0) gives one status beat, set up
// in StAdd, with dropped set when all QueueDepth slots are in use.
// A tick command (op 1) advances the counter, then pops expired timers from
// the head of the chain, earliest first, one per cycle apart from rearms: a
// plain timer gives one expiry beat, the task-switch timer gives no beat and
// is put back in StRearm at counter plus period (plus 1 if period is 0).
// A closing beat (kind 2, last set) ends the tick. busy drops in the cycle
// the last beat is driven, so a command is taken only when the previous is done.
// Each result beat is on result_o for one cycle with result_valid_o high;
// the receiver cannot stall. The sort is done by the cell chain as each
// entry is inserted, so throughput is bound by the pop/rearm sequencer.
// Config writes (cfg_valid_i/cfg_ready_o) are taken at any time and must
// only happen while idle. Reset empties the queue, zeroes the counter and
// loads tag 0x7fffffff and period 2.

module timer_deadline_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  tdq_pkg::cmd_t                    cmd_i,
  output logic                             result_valid_o,
  output tdq_pkg::result_t                 result_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tdq_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tdq_pkg::CfgDataW-1:0]     cfg_data_i
);
  import tdq_pkg::*;

  state_e              state_q, state_d;
  cmd_t                cmd_q;
  logic [DlW-1:0]      tick_q;
  logic [CntW-1:0]     cnt_q, budget_q;
  logic                sw_q;
  logic [DlW-1:0]      rearm_dl_q;
  logic [TagW-1:0]     task_tag_q;
  logic [PerW-1:0]     task_per_q;
  result_t             res_q, res_d;
  logic                res_valid_q, res_valid_d;

  cell_ctl_t           ctl;
  entry_t              ent   [QueueDepth];
  logic [QueueDepth-1:0] gt;
  logic [DlW-1:0]      per;
  logic                accept, hit, is_task;
  logic                rearm_go;

  assign accept      = start && !busy;
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  assign per     = (task_per_q == '0) ? DlW'(1) : DlW'(task_per_q);
  assign hit     = (budget_q != '0) && (cnt_q != '0) && (ent[0].dl <= tick_q);
  assign is_task = (ent[0].tag == task_tag_q);

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    tdq_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .valid_i    (CntW'(i) < cnt_q),
      .prev_ent_i ((i == 0) ? ent[0] : ent[(i == 0) ? 0 : i - 1]),
      .prev_gt_i  ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .next_ent_i (ent[(i == QueueDepth - 1) ? i : i + 1]),
      .ent_o      (ent[i]),
      .gt_o       (gt[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = (cmd_i.op == OpTick) ? StScan : StAdd;
        end
      end
      StAdd: begin
        state_d = StIdle;
      end
      StScan: begin
        if (!hit) begin
          state_d = StIdle;
        end else if (is_task) begin
          state_d = StRearm;
        end
      end
      StRearm: begin
        state_d = StScan;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctl         = '0;
    res_d       = '0;
    res_valid_d = 1'b0;
    rearm_go    = 1'b0;
    case (state_q)
      StAdd: begin
        ctl.ins       = (cnt_q < CntW'(QueueDepth));
        ctl.ent       = '{dl: cmd_q.new_deadline, tag: cmd_q.new_tag};
        res_d.kind    = KindAdd;
        res_d.dropped = !(cnt_q < CntW'(QueueDepth));
        res_d.last    = 1'b1;
        res_valid_d   = 1'b1;
      end
      StScan: begin
        if (hit) begin
          ctl.pop = 1'b1;
          if (is_task) begin
            rearm_go = 1'b1;
          end else begin
            res_d.kind           = KindExpire;
            res_d.fired_deadline = ent[0].dl;
            res_d.fired_tag      = ent[0].tag;
            res_valid_d          = 1'b1;
          end
        end else begin
          res_d.kind        = KindTick;
          res_d.switch_task = sw_q;
          res_d.last        = 1'b1;
          res_valid_d       = 1'b1;
        end
      end
      StRearm: begin
        ctl.ins = 1'b1;
        ctl.ent = '{dl: rearm_dl_q, tag: task_tag_q};
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tick_q      <= '0;
      cnt_q       <= '0;
      budget_q    <= '0;
      sw_q        <= 1'b0;
      res_valid_q <= 1'b0;
      task_tag_q  <= 32'h7fff_ffff;
      task_per_q  <= 16'd2;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (accept && (cmd_i.op == OpTick)) begin
        tick_q   <= tick_q + DlW'(1);
        budget_q <= cnt_q;
        sw_q     <= 1'b0;
      end
      if (ctl.pop) begin
        cnt_q    <= cnt_q - CntW'(1);
        budget_q <= budget_q - CntW'(1);
      end else if (ctl.ins) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (rearm_go) begin
        sw_q <= 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegTaskTag:    task_tag_q <= cfg_data_i[TagW-1:0];
          RegTaskPeriod: task_per_q <= cfg_data_i[PerW-1:0];
          default:       task_tag_q <= task_tag_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (rearm_go) begin
      rearm_dl_q <= tick_q + per;
    end
  end

endmodule
